FILE: hdl/adaptive_three_zone_smoother_top_defines.svh
// assertion macros for the adaptive three-zone smoother
// used by the port checker; expects clk_i and rst_ni in scope
`ifndef ADAPTIVE_THREE_ZONE_SMOOTHER_TOP_DEFINES_SVH
`define ADAPTIVE_THREE_ZONE_SMOOTHER_TOP_DEFINES_SVH

// checked only while out of reset
`define ATZS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ATZS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/atzs_pkg.sv
// types and constants for the adaptive three-zone smoother
// no dependencies
package atzs_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int THR_BITS       = 16;
  localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
  localparam int DIFF_BITS      = SAMPLE_BITS + 1;
  localparam int PROD_BITS      = GAIN_BITS + 1 + DIFF_BITS;
  localparam int CFG_DATA_BITS  = 17;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_JUMP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MID_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SMOOTHING_GAIN = 2'd2;

  localparam logic [THR_BITS-1:0]  JUMP_THRESHOLD_RST = 16'd4096;
  localparam logic [THR_BITS-1:0]  MID_THRESHOLD_RST  = 16'd512;
  localparam logic [GAIN_BITS-1:0] SMOOTHING_GAIN_RST = 17'd16384;

  typedef enum logic [1:0] {
    ZONE_FOLLOW  = 2'd0,
    ZONE_AVERAGE = 2'd1,
    ZONE_EXP     = 2'd2
  } zone_e;

  typedef struct packed {
    logic [THR_BITS-1:0]  jump_threshold;
    logic [THR_BITS-1:0]  mid_threshold;
    logic [GAIN_BITS-1:0] smoothing_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smooth_x;
    logic signed [SAMPLE_BITS-1:0] smooth_y;
    logic signed [SAMPLE_BITS-1:0] smooth_z;
    zone_e                         zone_x;
    zone_e                         zone_y;
    zone_e                         zone_z;
  } out_t;

endpackage

FILE: hdl/adaptive_three_zone_smoother_top.sv
// Adaptive three-zone smoother: one three-axis sample per transfer, one result per sample.
// A sample sits in an input register, all three axes are worked out combinationally (one
// 18x17 multiply per axis) and the result and the new axis state are stored together, so
// a sample can be taken every cycle unless the input stalls; each result goes from the
// input register to the result register. An output stall holds the result register and
// then the input register; the input stalls only while both are full. The user must
// write registers through the plain write port while idle; the block does not enforce it.
module adaptive_three_zone_smoother_top import atzs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_t                     out_data_o
);

  cfg_t cfg_q, cfg_d;
  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q, out_data_d;
  logic advance;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_JUMP_THRESHOLD: cfg_d.jump_threshold = cfg_wdata_i[THR_BITS-1:0];
        CFG_MID_THRESHOLD:  cfg_d.mid_threshold  = cfg_wdata_i[THR_BITS-1:0];
        CFG_SMOOTHING_GAIN: cfg_d.smoothing_gain = cfg_wdata_i[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RST;
      cfg_q.mid_threshold  <= MID_THRESHOLD_RST;
      cfg_q.smoothing_gain <= SMOOTHING_GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  atzs_axis u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (in_data_q.sample_x),
    .cfg_i    (cfg_q),
    .smooth_o (out_data_d.smooth_x),
    .zone_o   (out_data_d.zone_x)
  );

  atzs_axis u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (in_data_q.sample_y),
    .cfg_i    (cfg_q),
    .smooth_o (out_data_d.smooth_y),
    .zone_o   (out_data_d.zone_y)
  );

  atzs_axis u_axis_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (in_data_q.sample_z),
    .cfg_i    (cfg_q),
    .smooth_o (out_data_d.smooth_z),
    .zone_o   (out_data_d.zone_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/atzs_axis.sv
// one axis of the smoother: zone select, average, gain multiply, held state
// depends on atzs_pkg
module atzs_axis import atzs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  cfg_t                          cfg_i,
  output logic signed [SAMPLE_BITS-1:0] smooth_o,
  output zone_e                         zone_o
);

  logic signed [SAMPLE_BITS-1:0] last_q;
  logic signed [DIFF_BITS-1:0]   sample_ext;
  logic signed [DIFF_BITS-1:0]   last_ext;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [DIFF_BITS-1:0]   sum;
  logic signed [DIFF_BITS-1:0]   step;
  logic signed [DIFF_BITS-1:0]   exp_sum;
  logic [DIFF_BITS-1:0]          mag;
  logic [GAIN_BITS-1:0]          gain;
  logic signed [PROD_BITS-1:0]   prod;

  always_comb begin
    sample_ext = {sample_i[SAMPLE_BITS-1], sample_i};
    last_ext   = {last_q[SAMPLE_BITS-1], last_q};
    diff       = sample_ext - last_ext;
    sum        = sample_ext + last_ext;
    mag        = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
    gain       = (cfg_i.smoothing_gain > GAIN_ONE) ? GAIN_ONE : cfg_i.smoothing_gain;
    prod       = $signed({1'b0, gain}) * diff;
    // floor of the scaled product, fits since it lies between zero and diff
    step       = prod[GAIN_FRAC_BITS +: DIFF_BITS];
    exp_sum    = last_ext + step;

    if (mag > {1'b0, cfg_i.jump_threshold}) begin
      smooth_o = sample_i;
      zone_o   = ZONE_FOLLOW;
    end else if (mag > {1'b0, cfg_i.mid_threshold}) begin
      smooth_o = sum[SAMPLE_BITS:1];
      zone_o   = ZONE_AVERAGE;
    end else begin
      smooth_o = exp_sum[SAMPLE_BITS-1:0];
      zone_o   = ZONE_EXP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (en_i) begin
      last_q <= smooth_o;
    end
  end

endmodule

FILE: hdl/atzs_checker.sv
// port checker for the adaptive three-zone smoother, bound to the top level
// depends on atzs_pkg and the assertion macro header
`include "adaptive_three_zone_smoother_top_defines.svh"

module atzs_checker import atzs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  localparam logic [1:0] ZONE_SPARE = 2'd3;

  logic in_xfer;
  logic out_held;
  logic zone_bad;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign zone_bad = (out_data_o.zone_x == ZONE_SPARE) || (out_data_o.zone_y == ZONE_SPARE) ||
                    (out_data_o.zone_z == ZONE_SPARE);

  `ATZS_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `ATZS_ASSERT(a_zone_code, out_valid_o |-> !zone_bad, "zone code three on output")
  `ATZS_ASSERT(a_stall_cause, in_stall_o |-> out_held, "input stalled with free result register")
  `ATZS_ASSERT(a_no_invent, $rose(out_valid_o) |-> $past(in_xfer, 2), "result without a transfer")
  `ATZS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind adaptive_three_zone_smoother_top atzs_checker u_atzs_checker (.*);
